FILE: hw/rtl/swsc_pkg.sv
`default_nettype none
package swsc_pkg;

	localparam logic [14:0] Q8_MAX    = 15'd25600;
	localparam logic [14:0] Q8_LIMIT  = 15'd25601;
	localparam logic [9:0]  RAD_MAX_H = 10'd500;
	localparam logic [9:0]  RAD_MIN_H = 10'd40;

	// configuration register indexes
	localparam logic [1:0] REG_HALF_TRACK = 2'd0;
	localparam logic [1:0] REG_REAR_BASE  = 2'd1;
	localparam logic [1:0] REG_FRONT_BASE = 2'd2;
	localparam logic [1:0] REG_MID_OFFSET = 2'd3;

	// classified item handed from front to back
	typedef struct packed {
		logic               straight;
		logic               swap;
		logic [7:0]         mag;
		logic [8:0]         rad_h;
		logic signed [15:0] sval;
	} item_t;

	typedef struct packed {
		logic [9:0] half_track;
		logic [9:0] rear_base;
		logic [9:0] front_base;
		logic [9:0] mid_offset;
	} geom_t;

endpackage
`default_nettype wire

FILE: hw/rtl/six_wheel_steering_speed_calc_top.sv
// six-wheel rover wheel speed calculator
// input channel: drive_speed and steer_command, a beat moves on in_valid and
// in_ready; output channel: six Q8 wheel speeds on out_valid and out_ready.
// configuration: cfg_we writes cfg_data into register cfg_index (0 half track,
// 1 rear base, 2 front base, 3 middle offset); write only while idle.
// the front classifies a beat in the cycle it is taken and queues it; the
// back sequencer works one item at a time.
// a straight command goes from the queue pop to the output load; a turning command
// passes queue pop, multiply, multiply, square root at two bits a cycle,
// range check, division at two bits a cycle and output load.
// the sequencer takes a new item only after the last one is loaded into the
// output register, since all items share the root and divide sequence.
// the queue keeps accepting beats while the output register waits, so a
// stalled receiver holds only the back; the queue then fills and in_ready drops.
// reset clears the queue, the sequencer, out_valid and the geometry registers.
`default_nettype none
module six_wheel_steering_speed_calc_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [9:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [7:0]  drive_speed,
	input  wire logic signed [7:0]  steer_command,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      left_front_speed,
	output logic signed [15:0]      left_middle_speed,
	output logic signed [15:0]      left_back_speed,
	output logic signed [15:0]      right_front_speed,
	output logic signed [15:0]      right_middle_speed,
	output logic signed [15:0]      right_back_speed
);
	import swsc_pkg::*;

	geom_t              geom_q;
	item_t              front_item, queue_item;
	logic               full, not_empty, pop;
	logic signed [15:0] res [6];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_TRACK: geom_q.half_track <= cfg_data;
				REG_REAR_BASE:  geom_q.rear_base  <= cfg_data;
				REG_FRONT_BASE: geom_q.front_base <= cfg_data;
				REG_MID_OFFSET: geom_q.mid_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !full;

	swsc_front u_front (
		.drive_speed   (drive_speed),
		.steer_command (steer_command),
		.item          (front_item)
	);

	swsc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !full),
		.push_item (front_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (queue_item),
		.not_empty (not_empty)
	);

	swsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom_q),
		.item_valid (not_empty),
		.item       (queue_item),
		.item_pop   (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.res        (res)
	);

	assign left_front_speed   = res[0];
	assign left_middle_speed  = res[1];
	assign left_back_speed    = res[2];
	assign right_front_speed  = res[3];
	assign right_middle_speed = res[4];
	assign right_back_speed   = res[5];

endmodule
`default_nettype wire

FILE: hw/rtl/swsc_front.sv
`default_nettype none
module swsc_front (
	input  wire logic signed [7:0] drive_speed,
	input  wire logic signed [7:0] steer_command,
	output swsc_pkg::item_t        item
);
	import swsc_pkg::*;

	logic [7:0]         acmd;
	logic signed [11:0] rad_raw;

	// magnitude, radius in half units, straight value
	always_comb begin
		acmd    = steer_command[7] ? 8'(-steer_command) : 8'(steer_command);
		rad_raw = 12'sd500 - 12'($signed({4'b0, acmd}) * 12'sd5);
		item.straight = (steer_command == 8'sd0);
		item.swap     = !steer_command[7] && (steer_command != 8'sd0);
		item.mag      = drive_speed[7] ? 8'(-drive_speed) : 8'(drive_speed);
		if (rad_raw < $signed({2'b0, RAD_MIN_H})) begin
			item.rad_h = RAD_MIN_H[8:0];
		end else begin
			item.rad_h = rad_raw[8:0];
		end
		// speeds beyond plus or minus 100 saturate
		if (drive_speed > 8'sd100) begin
			item.sval = $signed({1'b0, Q8_MAX});
		end else if (drive_speed < -8'sd100) begin
			item.sval = -$signed({1'b0, Q8_MAX});
		end else begin
			item.sval = {drive_speed, 8'b0};
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/swsc_fifo.sv
`default_nettype none
module swsc_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  swsc_pkg::item_t      push_item,
	output logic                 full,
	input  wire logic            pop,
	output swsc_pkg::item_t      pop_item,
	output logic                 not_empty
);
	import swsc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_item  = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/swsc_back.sv
`default_nettype none
module swsc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  swsc_pkg::geom_t         geom,
	input  wire logic               item_valid,
	input  swsc_pkg::item_t         item,
	output logic                    item_pop,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [15:0]      res [6]
);
	import swsc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_SQRT, ST_OVF, ST_DIV, ST_DONE
	} state_t;

	typedef struct packed {
		logic [29:0] rem;
		logic [27:0] root;
	} sq_t;

	// one digit of the square root recurrence
	function automatic sq_t sq_step(input sq_t s, input logic [1:0] bits);
		logic [31:0] r4;
		logic [31:0] t;
		sq_t         o;
		r4 = {s.rem, bits};
		t  = {2'b0, s.root, 2'b01};
		if (r4 >= t) begin
			o.rem  = 30'(r4 - t);
			o.root = {s.root[26:0], 1'b1};
		end else begin
			o.rem  = r4[29:0];
			o.root = {s.root[26:0], 1'b0};
		end
		return o;
	endfunction

	state_t             state_q;
	item_t              it_q;
	logic [3:0]         cnt_q;
	logic [23:0]        n_q   [4];
	logic [14:0]        msq_q;
	logic [18:0]        midv_q;
	logic [11:0]        den_q;
	logic [55:0]        rad_q [4];
	sq_t                sq_q  [4];
	logic [27:0]        midn_q;
	logic [12:0]        drem_q [5];
	logic [15:0]        quo_q [5];
	logic [4:0]         ovf_q;
	logic signed [15:0] out_q [6];
	logic               ov_q;
	logic               out_load;

	logic [11:0] lat_out, lat_in, mid_abs;
	logic [10:0] lon_f, lon_b;
	logic [12:0] div_w;
	logic [14:0] lmid;
	logic [14:0] fin [5];
	logic [14:0] w [6];

	// geometry in half units
	always_comb begin
		lon_f   = {geom.front_base, 1'b0};
		lon_b   = {geom.rear_base, 1'b0};
		lat_out = 12'(it_q.rad_h) + 12'({geom.half_track, 1'b0});
		if ({3'b0, it_q.rad_h} >= {geom.half_track, 1'b0}) begin
			lat_in = 12'(12'(it_q.rad_h) - 12'({geom.half_track, 1'b0}));
		end else begin
			lat_in = 12'(12'({geom.half_track, 1'b0}) - 12'(it_q.rad_h));
		end
		if ({3'b0, it_q.rad_h} >= {geom.mid_offset, 1'b0}) begin
			mid_abs = 12'(12'(it_q.rad_h) - 12'({geom.mid_offset, 1'b0}));
		end else begin
			mid_abs = 12'(12'({geom.mid_offset, 1'b0}) - 12'(it_q.rad_h));
		end
		div_w = {den_q, 1'b0};
		lmid  = ({1'b0, it_q.mag, 8'b0} > {1'b0, Q8_MAX}) ? Q8_MAX : 15'({it_q.mag, 8'b0});
		for (int k = 0; k < 5; k++) begin
			fin[k] = ovf_q[k] ? Q8_MAX : quo_q[k][14:0];
		end
		// before the side swap
		w[0] = fin[0];
		w[1] = lmid;
		w[2] = fin[1];
		w[3] = fin[2];
		w[4] = fin[4];
		w[5] = fin[3];
	end

	assign item_pop  = (state_q == ST_IDLE) && item_valid;
	assign out_load  = (state_q == ST_DONE) && (!ov_q || out_ready);
	assign out_valid = ov_q;
	assign res       = out_q;

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			ov_q <= out_load || (ov_q && !out_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						it_q    <= item;
						state_q <= item.straight ? ST_DONE : ST_MUL1;
					end
				end
				ST_MUL1: begin
					n_q[0] <= 24'(lon_f * lon_f) + 24'(lat_out * lat_out);
					n_q[1] <= 24'(lon_b * lon_b) + 24'(lat_out * lat_out);
					n_q[2] <= 24'(lon_f * lon_f) + 24'(lat_in * lat_in);
					n_q[3] <= 24'(lon_b * lon_b) + 24'(lat_in * lat_in);
					msq_q  <= 15'(it_q.mag * it_q.mag);
					midv_q <= 19'(it_q.mag * mid_abs);
					den_q  <= 12'(it_q.rad_h) + 12'({geom.mid_offset, 1'b0});
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					for (int k = 0; k < 4; k++) begin
						rad_q[k] <= {38'(msq_q * n_q[k]), 18'b0};
						sq_q[k]  <= '0;
					end
					midn_q  <= {midv_q, 9'b0};
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					for (int k = 0; k < 4; k++) begin
						sq_q[k]  <= sq_step(sq_step(sq_q[k], rad_q[k][55:54]),
							rad_q[k][53:52]);
						rad_q[k] <= {rad_q[k][51:0], 4'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd13) begin
						state_q <= ST_OVF;
					end
				end
				ST_OVF: begin
					for (int k = 0; k < 5; k++) begin
						logic [28:0] num;
						num = 29'(midn_q) + 29'(den_q);
						if (k < 4) begin
							num = 29'(sq_q[k[1:0]].root) + 29'(den_q);
						end
						ovf_q[k]  <= (30'(num) >= 30'(div_w * Q8_LIMIT));
						drem_q[k] <= num[28:16];
						quo_q[k]  <= num[15:0];
					end
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					for (int k = 0; k < 5; k++) begin
						logic [13:0] a, b;
						logic [12:0] r1;
						logic        q1, q2;
						a  = {drem_q[k], quo_q[k][15]};
						q1 = (a >= 14'(div_w));
						r1 = q1 ? 13'(a - 14'(div_w)) : a[12:0];
						b  = {r1, quo_q[k][14]};
						q2 = (b >= 14'(div_w));
						drem_q[k] <= q2 ? 13'(b - 14'(div_w)) : b[12:0];
						quo_q[k]  <= {quo_q[k][13:0], q1, q2};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd7) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						for (int k = 0; k < 6; k++) begin
							if (it_q.straight) begin
								out_q[k] <= it_q.sval;
							end else if (it_q.swap) begin
								out_q[k] <= $signed({1'b0, w[(k + 3) % 6]});
							end else begin
								out_q[k] <= $signed({1'b0, w[k]});
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
